### src/vpid_pkg.sv
// vpid_pkg: shared types and constants for the velocity PID heater drive.
// Used by every module of the block; depends on nothing.

package vpid_pkg;

  localparam int TEMP_W   = 14;
  localparam int GAIN_W   = 12;
  localparam int PERIOD_W = 10;
  localparam int DRIVE_W  = 10;
  localparam int ERR_W    = TEMP_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT      = 3'd0,
    CFG_GAIN_NOW      = 3'd1,
    CFG_GAIN_PREV     = 3'd2,
    CFG_GAIN_PREV2    = 3'd3,
    CFG_SAMPLE_PERIOD = 3'd4
  } cfg_idx_t;

  // request codes
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [TEMP_W-1:0]          SETPOINT_RST   = 14'd1600;
  localparam logic signed [GAIN_W-1:0]   GAIN_NOW_RST   = 12'sd52;
  localparam logic signed [GAIN_W-1:0]   GAIN_PREV_RST  = -12'sd50;
  localparam logic signed [GAIN_W-1:0]   GAIN_PREV2_RST = 12'sd0;
  localparam logic [PERIOD_W-1:0]        PERIOD_RST     = 10'd1000;

  typedef struct packed {
    logic [TEMP_W-1:0]        setpoint;
    logic signed [GAIN_W-1:0] gain_now;
    logic signed [GAIN_W-1:0] gain_prev;
    logic signed [GAIN_W-1:0] gain_prev2;
    logic [PERIOD_W-1:0]      sample_period;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [TEMP_W-1:0] temperature;
  } item_t;

  typedef struct packed {
    logic               heater_level;
    logic               sample_due;
    logic [DRIVE_W-1:0] drive;
    logic               primed;
  } result_t;

endpackage

### src/vpid_cfg.sv
// vpid_cfg: configuration register file (setpoint, gains, sample period).
// Depends on vpid_pkg.

module vpid_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [vpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output vpid_pkg::cfg_t                      cfg
);
  import vpid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SETPOINT:      cfg_nxt.setpoint      = cfg_wdata[TEMP_W-1:0];
        CFG_GAIN_NOW:      cfg_nxt.gain_now      = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_PREV:     cfg_nxt.gain_prev     = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_PREV2:    cfg_nxt.gain_prev2    = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_SAMPLE_PERIOD: cfg_nxt.sample_period = cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint      <= SETPOINT_RST;
      cfg_r.gain_now      <= GAIN_NOW_RST;
      cfg_r.gain_prev     <= GAIN_PREV_RST;
      cfg_r.gain_prev2    <= GAIN_PREV2_RST;
      cfg_r.sample_period <= PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/vpid_in_reg.sv
// vpid_in_reg: input register stage with valid/stall handshake.
// Depends on vpid_pkg.

module vpid_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vpid_pkg::item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output vpid_pkg::item_t s1_item
);
  import vpid_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  // stage is free when empty or its word moves on this cycle
  assign load      = !valid_r || advance;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### src/vpid_core.sv
// vpid_core: loop state (tick count, on-time, drive accumulator, error history)
// and the update for one word, registered on fire. Depends on vpid_pkg.

module vpid_core #(
  parameter int DRIVE_MAX   = 1000,
  parameter int FRAC_BITS   = 4,
  parameter int START_DRIVE = 500
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  vpid_pkg::item_t   item,
  input  vpid_pkg::cfg_t    cfg,
  output vpid_pkg::result_t result
);
  import vpid_pkg::*;

  localparam int ACC_W  = DRIVE_W + FRAC_BITS;
  localparam int PROD_W = GAIN_W + ERR_W;
  localparam int SUM_W  = ((ACC_W + 1 > PROD_W + 2) ? ACC_W + 1 : PROD_W + 2) + 1;
  localparam logic signed [SUM_W-1:0] ACC_TOP =
    SUM_W'(DRIVE_MAX) <<< FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_RST = ACC_W'(START_DRIVE) << FRAC_BITS;

  logic [PERIOD_W-1:0]     tick_count_r, tick_count_nxt;
  logic [DRIVE_W-1:0]      on_time_r, on_time_nxt;
  logic [ACC_W-1:0]        drive_acc_r, drive_acc_nxt;
  logic signed [ERR_W-1:0] err_newest_r, err_newest_nxt;
  logic signed [ERR_W-1:0] err_mid_r, err_mid_nxt;
  logic signed [ERR_W-1:0] err_oldest_r, err_oldest_nxt;
  logic [1:0]              prime_count_r, prime_count_nxt;

  logic [PERIOD_W-1:0]      tick_inc;
  logic signed [ERR_W-1:0]  err_in;
  logic signed [PROD_W-1:0] prod_now, prod_prev, prod_prev2;
  logic signed [SUM_W-1:0]  acc_sum;
  logic [ACC_W-1:0]         acc_clamped;
  logic [1:0]               prime_inc;

  assign tick_inc  = tick_count_r + PERIOD_W'(1);
  assign err_in    = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, item.temperature});
  assign prime_inc = (prime_count_r == 2'd3) ? 2'd3 : prime_count_r + 2'd1;

  // multiply uses the history before it shifts: newest weight sees the new error
  assign prod_now   = PROD_W'(cfg.gain_now)   * PROD_W'(err_in);
  assign prod_prev  = PROD_W'(cfg.gain_prev)  * PROD_W'(err_newest_r);
  assign prod_prev2 = PROD_W'(cfg.gain_prev2) * PROD_W'(err_mid_r);

  assign acc_sum = $signed({1'b0, drive_acc_r}) + SUM_W'(prod_now)
                 + SUM_W'(prod_prev) + SUM_W'(prod_prev2);

  always_comb begin
    if (acc_sum > ACC_TOP) begin
      acc_clamped = ACC_TOP[ACC_W-1:0];
    end else if (acc_sum < 0) begin
      acc_clamped = '0;
    end else begin
      acc_clamped = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    tick_count_nxt  = tick_count_r;
    on_time_nxt     = on_time_r;
    drive_acc_nxt   = drive_acc_r;
    err_newest_nxt  = err_newest_r;
    err_mid_nxt     = err_mid_r;
    err_oldest_nxt  = err_oldest_r;
    prime_count_nxt = prime_count_r;
    result.heater_level = 1'b0;
    result.sample_due   = 1'b0;

    if (item.req_type == REQ_TICK) begin
      if (tick_inc >= cfg.sample_period) begin
        result.sample_due = 1'b1;
        tick_count_nxt    = '0;
      end else begin
        tick_count_nxt = tick_inc;
      end
      if (on_time_r != '0) begin
        on_time_nxt = on_time_r - DRIVE_W'(1);
      end else begin
        result.heater_level = 1'b1;
      end
    end else begin
      err_oldest_nxt  = err_mid_r;
      err_mid_nxt     = err_newest_r;
      err_newest_nxt  = err_in;
      prime_count_nxt = prime_inc;
      if (prime_inc == 2'd3) begin
        drive_acc_nxt = acc_clamped;
        on_time_nxt   = acc_clamped[ACC_W-1:FRAC_BITS];
      end
    end

    result.drive  = on_time_nxt;
    result.primed = (prime_count_nxt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      on_time_r     <= '0;
      drive_acc_r   <= ACC_RST;
      err_newest_r  <= '0;
      err_mid_r     <= '0;
      err_oldest_r  <= '0;
      prime_count_r <= '0;
    end else if (fire) begin
      tick_count_r  <= tick_count_nxt;
      on_time_r     <= on_time_nxt;
      drive_acc_r   <= drive_acc_nxt;
      err_newest_r  <= err_newest_nxt;
      err_mid_r     <= err_mid_nxt;
      err_oldest_r  <= err_oldest_nxt;
      prime_count_r <= prime_count_nxt;
    end
  end

endmodule

### src/velocity_pid_heater_drive.sv
// velocity_pid_heater_drive: top level, output register and assertions.
// Depends on vpid_pkg, vpid_cfg, vpid_in_reg, vpid_core.
//
// Usage:
//   Input words (in_valid/in_stall) are either a timer tick (req_type 0) or
//   a temperature sample (req_type 1, in_temperature in 1/16 degree).
//   Every word gives exactly one result word on out_valid/out_stall:
//   heater pin level and sample-due flag for a tick, the on-time counter
//   (out_drive) and the primed flag for both kinds.
//   A word is accepted into the input register, then the loop state is
//   updated and the result lands in the output register.
//   Throughput is one word per cycle while out_stall is low; the limit is the
//   state update (three 12x15 multiplies, accumulate, clamp to 0..DRIVE_MAX).
//   While the receiver stalls, the output register holds its word, the
//   input register fills, and then in_stall rises.
//   Synchronous reset (rst_n low) empties both stages, loads the register
//   defaults and clears the loop state; the accumulator starts at
//   START_DRIVE. Config writes (cfg_wr_en) are taken any cycle but are
//   meant for when the block is idle.

module velocity_pid_heater_drive #(
  parameter int DRIVE_MAX   = 1000,
  parameter int FRAC_BITS   = 4,
  parameter int START_DRIVE = 500
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [vpid_pkg::TEMP_W-1:0]         in_temperature,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_heater_level,
  output logic                                out_sample_due,
  output logic [vpid_pkg::DRIVE_W-1:0]        out_drive,
  output logic                                out_primed,
  input  logic                                cfg_wr_en,
  input  logic [vpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vpid_pkg::*;

  localparam int DRIVE_WIDTH_CHECK = DRIVE_W + 1;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s2_ready;
  logic    fire;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  assign in_item.req_type    = in_req_type;
  assign in_item.temperature = in_temperature;

  vpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vpid_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (s2_ready),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  vpid_core #(
    .DRIVE_MAX   (DRIVE_MAX),
    .FRAC_BITS   (FRAC_BITS),
    .START_DRIVE (START_DRIVE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (core_res)
  );

  assign s2_ready      = !out_valid_r || !out_stall;
  assign fire          = s1_valid && s2_ready;
  assign out_valid_nxt = s2_ready ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heater_level = out_res_r.heater_level;
  assign out_sample_due   = out_res_r.sample_due;
  assign out_drive        = out_res_r.drive;
  assign out_primed       = out_res_r.primed;

`ifndef NO_ASSERTIONS
  // on-time never leaves its clamp range
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DRIVE_WIDTH_CHECK'(out_drive) <= DRIVE_WIDTH_CHECK'(DRIVE_MAX)))
    else $error("drive above DRIVE_MAX");

  // nothing loads the on-time counter before the loop is primed
  a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_primed) |-> (out_drive == '0))
    else $error("on-time loaded before primed");

  // heater pin high only once on-time has run out
  a_heater_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_heater_level) |-> (out_drive == '0))
    else $error("heater high with on-time left");

  // input side stalls only behind a held result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");
`endif

endmodule
